FILE: rtl/bjtid_pkg.sv
// types, codes and request builders for the bjt pinout and gain identifier
package bjtid_pkg;

  // sample and gain arithmetic widths
  localparam int unsigned ADC_BITS  = 10;
  localparam int unsigned HFE_W     = 16;
  localparam int unsigned PROD_W    = 2 * ADC_BITS;
  localparam int unsigned DIV_STEPS = PROD_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);
  localparam int unsigned CFG_W     = 16;
  localparam int unsigned CFG_IDX_W = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_VF_LOW    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VF_HIGH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HB_MIN    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FULL      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HFE_MAX   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DIODE_SET = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_HFE_SET   = 3'd7;

  // input mode and output kind codes
  localparam logic MODE_START  = 1'b0;
  localparam logic MODE_SAMPLE = 1'b1;
  localparam logic KIND_REQ    = 1'b0;
  localparam logic KIND_RESULT = 1'b1;

  // pass patterns of the four diode tests
  localparam logic [3:0] FLAGS_NPN = 4'b0011;
  localparam logic [3:0] FLAGS_PNP = 4'b1100;

  localparam logic [1:0] PIN0     = 2'd0;
  localparam logic [1:0] PIN1     = 2'd1;
  localparam logic [1:0] PIN2     = 2'd2;
  localparam logic [1:0] LAST_TEST = 2'd3;

  typedef enum logic [2:0] {
    DRV_OFF       = 3'd0,
    DRV_HIGH      = 3'd1,
    DRV_LOW       = 3'd2,
    DRV_WEAK_HIGH = 3'd3,
    DRV_WEAK_LOW  = 3'd4
  } drive_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_DIODE_A,
    PH_DIODE_B,
    PH_GAIN1_A,
    PH_GAIN1_B,
    PH_GAIN2_A,
    PH_GAIN2_B
  } phase_e;

  typedef enum logic [1:0] {
    GS_IDLE,
    GS_MUL,
    GS_DIV,
    GS_DONE
  } gain_state_e;

  typedef struct packed {
    logic                mode;
    logic [ADC_BITS-1:0] adc_sample;
  } in_t;

  typedef struct packed {
    logic             kind;
    drive_e           pin0_drive;
    drive_e           pin1_drive;
    drive_e           pin2_drive;
    logic [1:0]       sense_pin;
    logic [7:0]       settle_ms;
    logic             found;
    logic             is_npn;
    logic [1:0]       base_pin;
    logic [1:0]       collector_pin;
    logic [1:0]       emitter_pin;
    logic [HFE_W-1:0] hfe;
  } out_t;

  // sequencer to gain unit
  typedef struct packed {
    logic start;
    logic ack;
  } gain_ctl_t;

  // gain unit to sequencer
  typedef struct packed {
    logic busy;
    logic done;
  } gain_sts_t;

  // lower and higher of the two pins that are not the base
  function automatic logic [1:0] other_lo(input logic [1:0] b);
    return (b == PIN0) ? PIN1 : PIN0;
  endfunction

  function automatic logic [1:0] other_hi(input logic [1:0] b);
    return (b == PIN2) ? PIN1 : PIN2;
  endfunction

  // request with up to three driven pins, the rest released
  function automatic out_t make_req(input logic [1:0] pa, input drive_e da,
                                    input logic [1:0] pb, input drive_e db,
                                    input logic [1:0] pc, input drive_e dc,
                                    input logic [1:0] sense, input logic [7:0] settle);
    out_t o;
    o            = '0;
    o.kind       = KIND_REQ;
    o.pin0_drive = (pa == PIN0) ? da : (pb == PIN0) ? db : (pc == PIN0) ? dc : DRV_OFF;
    o.pin1_drive = (pa == PIN1) ? da : (pb == PIN1) ? db : (pc == PIN1) ? dc : DRV_OFF;
    o.pin2_drive = (pa == PIN2) ? da : (pb == PIN2) ? db : (pc == PIN2) ? dc : DRV_OFF;
    o.sense_pin  = sense;
    o.settle_ms  = settle;
    return o;
  endfunction

  // diode test: b->x, b->y, x->b, y->b
  function automatic out_t diode_req(input logic [1:0] b, input logic [1:0] test,
                                     input logic second, input logic [7:0] settle);
    logic [1:0] from_pin;
    logic [1:0] to_pin;
    unique case (test)
      2'd0: begin
        from_pin = b;
        to_pin   = other_lo(b);
      end
      2'd1: begin
        from_pin = b;
        to_pin   = other_hi(b);
      end
      2'd2: begin
        from_pin = other_lo(b);
        to_pin   = b;
      end
      default: begin
        from_pin = other_hi(b);
        to_pin   = b;
      end
    endcase
    return make_req(from_pin, DRV_HIGH, to_pin, DRV_LOW, from_pin, DRV_HIGH,
                    second ? to_pin : from_pin, second ? 8'd0 : settle);
  endfunction

  // gain measurement with collector on the low (orient 0) or high other pin
  function automatic out_t gain_req(input logic [1:0] b, input logic npn,
                                    input logic orient, input logic second,
                                    input logic [7:0] settle);
    logic [1:0] coll;
    logic [1:0] emit;
    coll = orient ? other_hi(b) : other_lo(b);
    emit = orient ? other_lo(b) : other_hi(b);
    return make_req(b, npn ? DRV_WEAK_HIGH : DRV_WEAK_LOW,
                    coll, npn ? DRV_HIGH : DRV_LOW,
                    emit, npn ? DRV_LOW : DRV_HIGH,
                    second ? coll : b, second ? 8'd0 : settle);
  endfunction

endpackage

FILE: rtl/bjt_pin_type_hfe_identifier.sv
// top level: pinout search sequencer, configuration registers and result register
//
// channel  dir  handshake                 payload
// in       in   in_valid_i / in_ready_o   in_data_i  (mode, adc_sample)
// out      out  out_valid_o / out_ready_i out_data_o (request or final result)
// cfg      in   cfg_we_i                  cfg_idx_i, cfg_data_i
//
// a start or diode/first-gain sample loads its request into the output register when accepted
// each second gain sample runs the shared gain unit: one multiply plus a
// 20-step serial divide, and no next request is taken until the unit has finished
// in_ready_o is low while the gain unit works or while a request waits unclaimed
// and out_ready_i is low; reset clears the sequencer and loads the register defaults
module bjt_pin_type_hfe_identifier (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  bjtid_pkg::in_t                   in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output bjtid_pkg::out_t                  out_data_o,
  input  logic                             cfg_we_i,
  input  logic [bjtid_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [bjtid_pkg::CFG_W-1:0]      cfg_data_i
);
  import bjtid_pkg::*;

  // configuration registers
  logic [ADC_BITS-1:0] vf_low_q, vf_high_q, hb_min_q, ratio_q, full_q;
  logic [HFE_W-1:0]    hfe_max_q;
  logic [7:0]          diode_set_q, hfe_set_q;

  // sequencer state
  phase_e              phase_q, phase_d;
  logic [1:0]          base_q, base_d;
  logic [1:0]          test_q, test_d;
  logic [ADC_BITS-1:0] first_q, first_d;
  logic [3:0]          flags_q, flags_d;
  logic                npn_q, npn_d;
  logic [HFE_W-1:0]    gain1_q, gain1_d;

  // output register
  logic                out_valid_q, out_valid_d;
  out_t                out_q, out_d;
  logic                out_load;

  logic                acc;
  logic                out_free;
  logic [ADC_BITS-1:0] s;
  logic signed [ADC_BITS:0] vf;
  logic                pass;
  logic [3:0]          flags_n;
  logic                pick_first;
  out_t                fin;

  gain_ctl_t           gctl;
  gain_sts_t           gsts;
  logic [HFE_W-1:0]    gain;

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = !gsts.busy && out_free;
  assign acc        = in_valid_i && in_ready_o;
  assign s          = in_data_i.adc_sample;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_low_q    <= ADC_BITS'(30);
      vf_high_q   <= ADC_BITS'(246);
      hb_min_q    <= ADC_BITS'(3);
      ratio_q     <= ADC_BITS'(100);
      full_q      <= ADC_BITS'(1023);
      hfe_max_q   <= HFE_W'(999);
      diode_set_q <= 8'd5;
      hfe_set_q   <= 8'd10;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_VF_LOW:    vf_low_q    <= cfg_data_i[ADC_BITS-1:0];
        REG_VF_HIGH:   vf_high_q   <= cfg_data_i[ADC_BITS-1:0];
        REG_HB_MIN:    hb_min_q    <= cfg_data_i[ADC_BITS-1:0];
        REG_RATIO:     ratio_q     <= cfg_data_i[ADC_BITS-1:0];
        REG_FULL:      full_q      <= cfg_data_i[ADC_BITS-1:0];
        REG_HFE_MAX:   hfe_max_q   <= cfg_data_i[HFE_W-1:0];
        REG_DIODE_SET: diode_set_q <= cfg_data_i[7:0];
        REG_HFE_SET:   hfe_set_q   <= cfg_data_i[7:0];
        default: begin
        end
      endcase
    end
  end

  // diode test verdict and flag update
  always_comb begin
    vf      = $signed({1'b0, first_q}) - $signed({1'b0, s});
    pass    = (vf > $signed({1'b0, vf_low_q})) && (vf < $signed({1'b0, vf_high_q}));
    flags_n = flags_q | (4'(pass) << test_q);
  end

  // final result from the two gains
  always_comb begin
    pick_first        = (gain1_q >= gain);
    fin               = '0;
    fin.kind          = KIND_RESULT;
    fin.found         = 1'b1;
    fin.is_npn        = npn_q;
    fin.base_pin      = base_q;
    fin.collector_pin = pick_first ? other_lo(base_q) : other_hi(base_q);
    fin.emitter_pin   = pick_first ? other_hi(base_q) : other_lo(base_q);
    fin.hfe           = pick_first ? gain1_q : gain;
  end

  // sequencer next state and request generation
  always_comb begin
    phase_d    = phase_q;
    base_d     = base_q;
    test_d     = test_q;
    first_d    = first_q;
    flags_d    = flags_q;
    npn_d      = npn_q;
    gain1_d    = gain1_q;
    out_load   = 1'b0;
    out_d      = out_q;
    gctl.start = 1'b0;
    gctl.ack   = 1'b0;

    // gain unit finished
    if (gsts.done) begin
      if (phase_q == PH_GAIN1_B) begin
        gain1_d  = gain;
        phase_d  = PH_GAIN2_A;
        gctl.ack = 1'b1;
      end else if (out_free) begin
        out_load = 1'b1;
        out_d    = fin;
        phase_d  = PH_IDLE;
        gctl.ack = 1'b1;
      end
    end

    // accepted request
    if (acc) begin
      if (in_data_i.mode == MODE_START) begin
        base_d   = PIN0;
        test_d   = '0;
        flags_d  = '0;
        npn_d    = 1'b0;
        gain1_d  = '0;
        first_d  = '0;
        phase_d  = PH_DIODE_A;
        out_load = 1'b1;
        out_d    = diode_req(PIN0, 2'd0, 1'b0, diode_set_q);
      end else begin
        unique case (phase_q)
          PH_DIODE_A: begin
            first_d  = s;
            phase_d  = PH_DIODE_B;
            out_load = 1'b1;
            out_d    = diode_req(base_q, test_q, 1'b1, diode_set_q);
          end
          PH_DIODE_B: begin
            out_load = 1'b1;
            flags_d  = flags_n;
            if (test_q != LAST_TEST) begin
              test_d  = test_q + 2'd1;
              phase_d = PH_DIODE_A;
              out_d   = diode_req(base_q, test_q + 2'd1, 1'b0, diode_set_q);
            end else if (flags_n == FLAGS_NPN || flags_n == FLAGS_PNP) begin
              npn_d   = (flags_n == FLAGS_NPN);
              phase_d = PH_GAIN1_A;
              out_d   = gain_req(base_q, flags_n == FLAGS_NPN, 1'b0, 1'b0, hfe_set_q);
            end else if (base_q != PIN2) begin
              base_d  = base_q + 2'd1;
              test_d  = '0;
              flags_d = '0;
              phase_d = PH_DIODE_A;
              out_d   = diode_req(base_q + 2'd1, 2'd0, 1'b0, diode_set_q);
            end else begin
              phase_d    = PH_IDLE;
              out_d      = '0;
              out_d.kind = KIND_RESULT;
            end
          end
          PH_GAIN1_A: begin
            first_d  = s;
            phase_d  = PH_GAIN1_B;
            out_load = 1'b1;
            out_d    = gain_req(base_q, npn_q, 1'b0, 1'b1, hfe_set_q);
          end
          PH_GAIN1_B: begin
            gctl.start = 1'b1;
            out_load   = 1'b1;
            out_d      = gain_req(base_q, npn_q, 1'b1, 1'b0, hfe_set_q);
          end
          PH_GAIN2_A: begin
            first_d  = s;
            phase_d  = PH_GAIN2_B;
            out_load = 1'b1;
            out_d    = gain_req(base_q, npn_q, 1'b1, 1'b1, hfe_set_q);
          end
          PH_GAIN2_B: begin
            gctl.start = 1'b1;
          end
          default: begin
          end
        endcase
      end
    end

    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // sequencer and output control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_IDLE;
      base_q      <= '0;
      test_q      <= '0;
      first_q     <= '0;
      flags_q     <= '0;
      npn_q       <= 1'b0;
      gain1_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      base_q      <= base_d;
      test_q      <= test_d;
      first_q     <= first_d;
      flags_q     <= flags_d;
      npn_q       <= npn_d;
      gain1_q     <= gain1_d;
      out_valid_q <= out_valid_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // shared gain unit
  bjtid_gain u_gain (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctl_i       (gctl),
    .npn_i       (npn_q),
    .bcode_i     (first_q),
    .ccode_i     (s),
    .full_scale_i(full_q),
    .ratio_i     (ratio_q),
    .hb_min_i    (hb_min_q),
    .hfe_max_i   (hfe_max_q),
    .sts_o       (gsts),
    .gain_o      (gain)
  );

  // gain unit only launched on a second gain sample
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    gctl.start |-> (phase_q == PH_GAIN1_B || phase_q == PH_GAIN2_B))
    else $error("gain unit started outside a gain sample");

  // gain phases only entered with a clean npn or pnp pattern
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_GAIN1_A) |-> (flags_q == FLAGS_NPN || flags_q == FLAGS_PNP))
    else $error("gain phase without a valid diode pattern");

  // an identified part has three distinct pins and a saturated gain
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.kind == KIND_RESULT && out_data_o.found) |->
      (out_data_o.base_pin != out_data_o.collector_pin &&
       out_data_o.base_pin != out_data_o.emitter_pin &&
       out_data_o.collector_pin != out_data_o.emitter_pin &&
       out_data_o.hfe <= hfe_max_q))
    else $error("inconsistent identification result");

  // the output register is never overwritten while a request waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |-> !out_load)
    else $error("pending request overwritten");

endmodule

FILE: rtl/bjtid_gain.sv
// gain unit: headroom, one multiply, then a bit-serial restoring divide
module bjtid_gain (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  bjtid_pkg::gain_ctl_t          ctl_i,
  input  logic                          npn_i,
  input  logic [bjtid_pkg::ADC_BITS-1:0] bcode_i,
  input  logic [bjtid_pkg::ADC_BITS-1:0] ccode_i,
  input  logic [bjtid_pkg::ADC_BITS-1:0] full_scale_i,
  input  logic [bjtid_pkg::ADC_BITS-1:0] ratio_i,
  input  logic [bjtid_pkg::ADC_BITS-1:0] hb_min_i,
  input  logic [bjtid_pkg::HFE_W-1:0]    hfe_max_i,
  output bjtid_pkg::gain_sts_t          sts_o,
  output logic [bjtid_pkg::HFE_W-1:0]    gain_o
);
  import bjtid_pkg::*;

  gain_state_e         state_q, state_d;
  logic                npn_q;
  logic [ADC_BITS-1:0] bcode_q;
  logic [ADC_BITS-1:0] ccode_q;
  logic [ADC_BITS-1:0] div_q;
  logic [ADC_BITS-1:0] rem_q;
  logic [PROD_W-1:0]   quo_q;
  logic [STEP_W-1:0]   step_q;
  logic                zero_q;

  logic signed [ADC_BITS:0] hb;
  logic signed [ADC_BITS:0] hc;
  logic                     hb_zero;
  logic [ADC_BITS:0]        trial;
  logic                     ge;

  // headrooms from the two latched codes
  always_comb begin
    if (npn_q) begin
      hb = $signed({1'b0, full_scale_i}) - $signed({1'b0, bcode_q});
      hc = $signed({1'b0, full_scale_i}) - $signed({1'b0, ccode_q});
    end else begin
      hb = $signed({1'b0, bcode_q});
      hc = $signed({1'b0, ccode_q});
    end
    hb_zero = (hb <= 0) || (hb < $signed({1'b0, hb_min_i})) || (hc <= 0);
  end

  // one restoring divide step
  always_comb begin
    trial = {rem_q, quo_q[PROD_W-1]};
    ge    = (trial >= {1'b0, div_q});
  end

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      GS_IDLE: if (ctl_i.start) state_d = GS_MUL;
      GS_MUL:  state_d = GS_DIV;
      GS_DIV:  if (step_q == STEP_W'(DIV_STEPS - 1)) state_d = GS_DONE;
      GS_DONE: if (ctl_i.ack) state_d = GS_IDLE;
      default: state_d = GS_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= GS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // operand latch, multiply and divide datapath
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      GS_IDLE: begin
        if (ctl_i.start) begin
          npn_q   <= npn_i;
          bcode_q <= bcode_i;
          ccode_q <= ccode_i;
        end
      end
      GS_MUL: begin
        zero_q <= hb_zero;
        div_q  <= hb[ADC_BITS-1:0];
        quo_q  <= PROD_W'(ratio_i) * PROD_W'(hc[ADC_BITS-1:0]);
        rem_q  <= '0;
        step_q <= '0;
      end
      GS_DIV: begin
        rem_q  <= ge ? ADC_BITS'(trial - {1'b0, div_q}) : trial[ADC_BITS-1:0];
        quo_q  <= {quo_q[PROD_W-2:0], ge};
        step_q <= step_q + STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

  // saturated result, held until acknowledged
  always_comb begin
    if (zero_q) begin
      gain_o = '0;
    end else if (quo_q > PROD_W'(hfe_max_i)) begin
      gain_o = hfe_max_i;
    end else begin
      gain_o = quo_q[HFE_W-1:0];
    end
  end

  assign sts_o.busy = (state_q != GS_IDLE);
  assign sts_o.done = (state_q == GS_DONE);

endmodule
